### src/barometer_compensation_unit_defines.svh
// ----------------------------------------------------------------------------
// Barometer compensation assertion macros
// Shared concurrent assertion forms used by the compensation unit.
// ----------------------------------------------------------------------------
`ifndef BAROMETER_COMPENSATION_UNIT_DEFINES_SVH
`define BAROMETER_COMPENSATION_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcu assertion failed");

`endif

### src/bcu_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Constants, register indexes and helpers for the compensation unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned AddrW = 5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TEMP   = 2'd0;
  localparam logic [1:0] REG_PLOW   = 2'd1;
  localparam logic [1:0] REG_PHIGH  = 2'd2;
  localparam logic [1:0] REG_PNINE  = 2'd3;

  localparam logic signed [63:0] FINE_OFFSET  = 64'sd128000;
  localparam logic [63:0]        PRESS_BASE   = 64'd1048576;
  localparam logic signed [63:0] PRESS_SCALE  = 64'sd3125;
  localparam logic signed [63:0] ROUND_HALF   = 64'sd128;
  localparam logic signed [63:0] DENOM_OFFSET = 64'sd1 <<< 47;

  function automatic logic signed [63:0] sext16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### src/barometer_compensation_unit.sv
// ----------------------------------------------------------------------------
// Barometer compensation unit
// Integer compensation of raw temperature and pressure samples.
// ----------------------------------------------------------------------------
// Usage: an input beat carries mode (0 temperature, 1 pressure) and a 20-bit
// raw_sample on in_valid/in_stall. One result beat (value, div_error) leaves
// on out_valid/out_stall for every input beat, in order.
// Calibration words are written over the APB-style port at 8*index; pready
// is always high and reads return the stored words.
// All arithmetic runs on one shared shift-add multiplier that retires one
// multiplier bit per cycle, and one restoring divider that retires one
// quotient bit per cycle. Each product runs through a load, a bit step for
// each of the 64 multiplier bits and a write back. A temperature beat needs
// three products; a pressure beat needs ten products plus a divide, or six
// products when the divisor turns out zero.
// The multiplier loop therefore sets the rate; one item is worked at a time
// and in_stall is high while it is in flight.
// The result sits in an output register; the next input beat is accepted
// while it waits for the receiver, and a finished result behind it waits
// until the output register is free.
// Reset clears the calibration registers, the stored fine temperature and
// all control state; a pressure beat before any temperature beat uses a
// fine temperature of zero.
`include "barometer_compensation_unit_defines.svh"

module barometer_compensation_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bcu_pkg::AddrW-1:0]   paddr,
  input  logic [bcu_pkg::DataW-1:0]   pwdata,
  output logic [bcu_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [19:0]                 raw_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          value,
  output logic                        div_error
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_WB, ST_DIV, ST_DIVFIX,
    ST_TSAT, ST_TOUT, ST_PSUM, ST_PFIN, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    SP_T0, SP_T1, SP_T2, SP_P0, SP_P1, SP_P2, SP_P3, SP_P4,
    SP_P5, SP_P6, SP_P7, SP_P8, SP_P9
  } step_t;

  // Calibration registers.
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  state_t state;
  step_t  step;
  logic [5:0] cnt;
  logic [19:0] adc;

  logic signed [31:0] fine;
  logic signed [63:0] ra, rs, rv2, rt, rp;

  // Multiplier and divider datapath registers.
  logic [63:0] ma, mb, macc;
  logic [63:0] dq, rem, dvs;
  logic        dneg;

  logic signed [31:0] rslt;
  logic               rerr;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:3])
      bcu_pkg::REG_TEMP:  prdata = {16'd0, temp_coeffs};
      bcu_pkg::REG_PLOW:  prdata = press_coeffs_low;
      bcu_pkg::REG_PHIGH: prdata = press_coeffs_high;
      bcu_pkg::REG_PNINE: prdata = {48'd0, press_coeff_nine};
      default:            prdata = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // The finished result moves into the output register when it is free.
  logic out_load;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // Operands of the product for the current step.
  logic signed [63:0] mul_a, mul_b;
  always_comb begin
    case (step)
      SP_T0: begin
        mul_a = $signed({47'd0, adc[19:3]}) - $signed({47'd0, temp_coeffs[15:0], 1'b0});
        mul_b = bcu_pkg::sext16(temp_coeffs[31:16]);
      end
      SP_T1: begin
        mul_a = $signed({48'd0, adc[19:4]}) - $signed({48'd0, temp_coeffs[15:0]});
        mul_b = mul_a;
      end
      SP_T2: begin
        mul_a = rs;
        mul_b = bcu_pkg::sext16(temp_coeffs[47:32]);
      end
      SP_P0: begin
        mul_a = ra;
        mul_b = ra;
      end
      SP_P1: begin
        mul_a = rs;
        mul_b = bcu_pkg::sext16(press_coeffs_high[31:16]);
      end
      SP_P2: begin
        mul_a = ra;
        mul_b = bcu_pkg::sext16(press_coeffs_high[15:0]);
      end
      SP_P3: begin
        mul_a = rs;
        mul_b = bcu_pkg::sext16(press_coeffs_low[47:32]);
      end
      SP_P4: begin
        mul_a = ra;
        mul_b = bcu_pkg::sext16(press_coeffs_low[31:16]);
      end
      SP_P5: begin
        mul_a = ra + bcu_pkg::DENOM_OFFSET;
        mul_b = $signed({48'd0, press_coeffs_low[15:0]});
      end
      SP_P6: begin
        mul_a = rt;
        mul_b = bcu_pkg::PRESS_SCALE;
      end
      SP_P7: begin
        mul_a = bcu_pkg::sext16(press_coeff_nine);
        mul_b = rp >>> 13;
      end
      SP_P8: begin
        mul_a = rs;
        mul_b = rp >>> 13;
      end
      SP_P9: begin
        mul_a = bcu_pkg::sext16(press_coeffs_high[63:48]);
        mul_b = rp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [63:0] prod;
  assign prod = $signed(macc);

  // One restoring divide step.
  logic [64:0] rem_sh;
  logic        dfit;
  assign rem_sh = {rem, dq[63]};
  assign dfit   = (rem_sh >= {1'b0, dvs});

  logic signed [63:0] fine64;
  assign fine64 = {{32{fine[31]}}, fine};

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      step              <= SP_T0;
      cnt               <= '0;
      out_valid         <= 1'b0;
      fine              <= '0;
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:3])
          bcu_pkg::REG_TEMP:  temp_coeffs       <= pwdata[47:0];
          bcu_pkg::REG_PLOW:  press_coeffs_low  <= pwdata;
          bcu_pkg::REG_PHIGH: press_coeffs_high <= pwdata;
          bcu_pkg::REG_PNINE: press_coeff_nine  <= pwdata[15:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            adc   <= raw_sample;
            rerr  <= 1'b0;
            ra    <= fine64 - bcu_pkg::FINE_OFFSET;
            step  <= mode ? SP_P0 : SP_T0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ma    <= mul_a;
          mb    <= mul_b;
          macc  <= '0;
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mb[0]) begin
            macc <= macc + ma;
          end
          ma  <= {ma[62:0], 1'b0};
          mb  <= {1'b0, mb[63:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          case (step)
            SP_T0: begin
              rt    <= prod >>> 11;
              step  <= SP_T1;
              state <= ST_LOAD;
            end
            SP_T1: begin
              rs    <= prod >>> 12;
              step  <= SP_T2;
              state <= ST_LOAD;
            end
            SP_T2: begin
              rt    <= rt + (prod >>> 14);
              state <= ST_TSAT;
            end
            SP_P0: begin
              rs    <= prod;
              step  <= SP_P1;
              state <= ST_LOAD;
            end
            SP_P1: begin
              rv2   <= prod;
              step  <= SP_P2;
              state <= ST_LOAD;
            end
            SP_P2: begin
              rv2   <= rv2 + (prod <<< 17)
                       + (bcu_pkg::sext16(press_coeffs_low[63:48]) <<< 35);
              step  <= SP_P3;
              state <= ST_LOAD;
            end
            SP_P3: begin
              rs    <= prod >>> 8;
              step  <= SP_P4;
              state <= ST_LOAD;
            end
            SP_P4: begin
              ra    <= rs + (prod <<< 12);
              step  <= SP_P5;
              state <= ST_LOAD;
            end
            SP_P5: begin
              ra <= prod >>> 33;
              if ((prod >>> 33) == 64'sd0) begin
                rerr  <= 1'b1;
                rslt  <= '0;
                state <= ST_OUT;
              end else begin
                rt    <= $signed((bcu_pkg::PRESS_BASE - {44'd0, adc}) << 31) - rv2;
                step  <= SP_P6;
                state <= ST_LOAD;
              end
            end
            SP_P6: begin
              // Divide magnitudes, fix the sign afterward.
              dq    <= prod[63] ? 64'(-prod) : 64'(prod);
              dvs   <= ra[63] ? 64'(-ra) : 64'(ra);
              dneg  <= prod[63] ^ ra[63];
              rem   <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end
            SP_P7: begin
              rs    <= prod;
              step  <= SP_P8;
              state <= ST_LOAD;
            end
            SP_P8: begin
              rs    <= prod >>> 25;
              step  <= SP_P9;
              state <= ST_LOAD;
            end
            SP_P9: begin
              rv2   <= prod >>> 19;
              state <= ST_PSUM;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          rem <= dfit ? 64'(rem_sh - {1'b0, dvs}) : rem_sh[63:0];
          dq  <= {dq[62:0], dfit};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ST_DIVFIX;
          end
        end
        ST_DIVFIX: begin
          rp    <= dneg ? $signed(-dq) : $signed(dq);
          step  <= SP_P7;
          state <= ST_LOAD;
        end
        ST_TSAT: begin
          fine  <= bcu_pkg::sat32(rt);
          state <= ST_TOUT;
        end
        ST_TOUT: begin
          rslt  <= bcu_pkg::sat32(((fine64 <<< 2) + fine64 + bcu_pkg::ROUND_HALF) >>> 8);
          state <= ST_OUT;
        end
        ST_PSUM: begin
          rt    <= rp + rs + rv2;
          state <= ST_PFIN;
        end
        ST_PFIN: begin
          rslt  <= bcu_pkg::sat32((rt >>> 8)
                   + (bcu_pkg::sext16(press_coeffs_high[47:32]) <<< 4));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            value     <= rslt;
            div_error <= rerr;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A new result only ever comes from the output-handoff state.
  `BCU_ASSERT_SAME(a_out_from_handoff, $rose(out_valid), $past(state) == ST_OUT)
  // An error result always carries a zero value.
  `BCU_ASSERT_SAME(a_err_zero, out_valid && div_error, value == 32'sd0)
  // An accepted beat always starts a product.
  `BCU_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, state == ST_LOAD)
  // The multiplier always runs its full bit count before write back.
  `BCU_ASSERT_SAME(a_mul_full, state == ST_WB, $past(cnt) == 6'd63)

endmodule

### sim/barometer_compensation_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer compensation unit testbench
// Drives raw temperature and pressure beats under random idling, predicts
// each compensated result from calibration words written over the APB-style
// port, and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module barometer_compensation_unit_test;

  typedef struct packed {
    logic        mode;
    logic [19:0] raw;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_error;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bcu_pkg::AddrW-1:0] paddr = '0;
  logic [bcu_pkg::DataW-1:0] pwdata = '0;
  logic [bcu_pkg::DataW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [19:0] raw_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic div_error;

  always #2 clk = ~clk;

  barometer_compensation_unit dut (.*);

  // Predictor state and its copy of the calibration words.
  logic [47:0] cal_temp;
  logic [63:0] cal_plow, cal_phigh;
  logic [15:0] cal_p9;
  logic signed [31:0] fine_t;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic signed [63:0] s16(logic [63:0] w, int pos);
    logic [15:0] f;
    f = w[pos +: 16];
    return {{48{f[15]}}, f};
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Works out the compensated reading for one beat and, for a temperature beat, updates fine_t.
  function automatic reading_t compensate(sample_t s);
    reading_t r;
    logic signed [63:0] adc, t1, t2, t3, a, d, v1, v2, p, num, q;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    adc = {44'd0, s.raw};
    r.value = '0;
    r.div_error = 1'b0;
    if (!s.mode) begin
      // Temperature products fit 64 bits, so plain arithmetic is exact here.
      t1 = {48'd0, cal_temp[15:0]};
      t2 = s16(cal_temp, 16);
      t3 = s16(cal_temp, 32);
      a = (adc >>> 3) - t1 * 2;
      v1 = (a * t2) >>> 11;
      d = (adc >>> 4) - t1;
      v2 = (((d * d) >>> 12) * t3) >>> 14;
      fine_t = clamp32(v1 + v2);
      r.value = clamp32(((64'(fine_t)) * 5 + 128) >>> 8);
    end else begin
      p1 = {48'd0, cal_plow[15:0]};
      p2 = s16(cal_plow, 16);
      p3 = s16(cal_plow, 32);
      p4 = s16(cal_plow, 48);
      p5 = s16(cal_phigh, 0);
      p6 = s16(cal_phigh, 16);
      p7 = s16(cal_phigh, 32);
      p8 = s16(cal_phigh, 48);
      p9 = s16({48'd0, cal_p9}, 0);
      v1 = 64'(fine_t) - 128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = (((v1 * v1) * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      if (v1 == 0) begin
        r.div_error = 1'b1;
      end else begin
        p = 64'sd1048576 - adc;
        num = ((p <<< 31) - v2) * 3125;
        if (num == {1'b1, 63'd0} && v1 == -64'sd1) q = num;
        else q = num / v1;
        p = q;
        v1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
        v2 = (p8 * p) >>> 19;
        p = (((p + v1) + v2) >>> 8) + (p7 <<< 4);
        r.value = clamp32(p);
      end
    end
    return r;
  endfunction

  // Driver: feeds beats from the pending queue, holding a stalled payload.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          expected_readings.push_back(compensate(s));
          in_valid <= 1'b1;
          mode <= s.mode;
          raw_sample <= s.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and redraws the stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected beat value=%0d div_error=%0b", $time, value, div_error);
          errors++;
        end else begin
          reading_t e;
          e = expected_readings.pop_front();
          if (value !== e.value) begin
            $display("%0t: value expected %0d actual %0d", $time, e.value, value);
            errors++;
          end
          if (div_error !== e.div_error) begin
            $display("%0t: div_error expected %0b actual %0b", $time, e.div_error,
                     div_error);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= bcu_pkg::AddrW'(idx) << 3; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bcu_pkg::REG_TEMP:  cal_temp = data[47:0];
      bcu_pkg::REG_PLOW:  cal_plow = data;
      bcu_pkg::REG_PHIGH: cal_phigh = data;
      bcu_pkg::REG_PNINE: cal_p9 = data[15:0];
      default: ;
    endcase
  endtask

  // Waits until every beat has been accepted and every result has come.
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Realistic calibration words with random spread, so the divisor is nonzero.
  task automatic program_typical();
    write_reg(bcu_pkg::REG_TEMP, 64'({16'($urandom_range(0, 100)),
                                      16'($urandom_range(26000, 27000)),
                                      16'($urandom_range(27000, 28500))}));
    write_reg(bcu_pkg::REG_PLOW, {16'($urandom_range(2000, 9000)),
                                  16'(-($urandom_range(2000, 4000))),
                                  16'(-($urandom_range(9000, 12000))),
                                  16'($urandom_range(30000, 40000))});
    write_reg(bcu_pkg::REG_PHIGH, {16'(-($urandom_range(10000, 13000))),
                                   16'($urandom_range(12000, 16000)),
                                   16'(-($urandom_range(0, 20))), 16'($urandom_range(0, 300))});
    write_reg(bcu_pkg::REG_PNINE, 64'($urandom_range(4000, 7000)));
  endtask

  task automatic add_random(int n, bit typical);
    sample_t s;
    repeat (n) begin
      s.mode = 1'($urandom_range(1));
      s.raw = typical ? 20'($urandom_range(300000, 700000)) : 20'($urandom);
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_p9 = '0; fine_t = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Pressure before any temperature beat, with all-zero calibration: the
    // divisor is zero, so this also covers the division error.
    s = '{1'b1, 20'd0};       pending_samples.push_back(s);
    s = '{1'b1, 20'hfffff};   pending_samples.push_back(s);
    s = '{1'b0, 20'hfffff};   pending_samples.push_back(s);
    drain();

    // Extreme calibration words: all ones, then the signed extremes.
    write_reg(bcu_pkg::REG_TEMP, 64'hffff_ffff_ffff);
    write_reg(bcu_pkg::REG_PLOW, '1);
    write_reg(bcu_pkg::REG_PHIGH, '1);
    write_reg(bcu_pkg::REG_PNINE, 64'hffff);
    s = '{1'b0, 20'd0};       pending_samples.push_back(s);
    s = '{1'b1, 20'd0};       pending_samples.push_back(s);
    s = '{1'b0, 20'hfffff};   pending_samples.push_back(s);
    s = '{1'b1, 20'hfffff};   pending_samples.push_back(s);
    drain();
    write_reg(bcu_pkg::REG_TEMP, 64'({16'h8000, 16'h7fff, 16'hffff}));
    write_reg(bcu_pkg::REG_PLOW, {16'h7fff, 16'h8000, 16'h7fff, 16'hffff});
    write_reg(bcu_pkg::REG_PHIGH, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_reg(bcu_pkg::REG_PNINE, 64'h8000);
    s = '{1'b0, 20'h55555};   pending_samples.push_back(s);
    s = '{1'b1, 20'haaaaa};   pending_samples.push_back(s);
    s = '{1'b0, 20'd1};       pending_samples.push_back(s);
    s = '{1'b1, 20'h80000};   pending_samples.push_back(s);
    drain();

    // Random phases with the three idling profiles.
    send_idle_pct = 14; recv_idle_pct = 48;
    program_typical();
    add_random(300, 1'b1);
    drain();
    write_reg(bcu_pkg::REG_PLOW, {$urandom, $urandom});
    write_reg(bcu_pkg::REG_PHIGH, {$urandom, $urandom});
    write_reg(bcu_pkg::REG_TEMP, {$urandom, $urandom});
    write_reg(bcu_pkg::REG_PNINE, 64'($urandom));
    add_random(60, 1'b0);
    drain();

    send_idle_pct = 48; recv_idle_pct = 14;
    program_typical();
    add_random(300, 1'b1);
    drain();
    write_reg(bcu_pkg::REG_PLOW, 64'h0000_0000_0000_0000);
    add_random(30, 1'b0);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    program_typical();
    add_random(330, 1'b1);
    drain();

    if (errors == 0) begin
      $display("barometer_compensation_unit verification clean");
    end else begin
      $display("barometer_compensation_unit verification failed");
    end
    $finish;
  end

  // About 1050 beats plus stalls fit well inside this timeout.
  initial begin
    #40000000;
    $display("barometer_compensation_unit verification failed");
    $finish;
  end

endmodule
